// ===== sv/dhks_pkg.sv =====
// Shared types and constants for the double-hash key set.
// Holds the transaction structs, tag, operation, status and state codes.
// No dependencies.
`default_nettype none

package dhks_pkg;

  localparam int CAPACITY_DEF = 1021;
  localparam int KEY_BITS_DEF = 32;
  localparam int KEY_FIELD_W  = 32;
  localparam int FUNC_W       = 2;
  localparam int STATUS_W     = 2;
  localparam int COUNT_W      = 10;
  localparam int STEP_PRIME   = 7;
  localparam int REM7_W       = 3;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_LOOKUP = 2'd1,
    FUNC_DELETE = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    TAG_EMPTY = 2'd0,
    TAG_USED  = 2'd1,
    TAG_TOMB  = 2'd2
  } tag_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_ZERO_KEY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_PROBE,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [FUNC_W-1:0]      func;
    logic [KEY_FIELD_W-1:0] key;
  } in_item_t;

  typedef struct packed {
    logic                found;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
  } out_item_t;

endpackage

`default_nettype wire

// ===== sv/dhks_mod_unit.sv =====
// Reduction of a key modulo the table size and modulo seven by reciprocal multiplication.
// Key captured on start, product registered the cycle after, remainders and done the cycle after that.
// Depends on dhks_pkg.
`default_nettype none

module dhks_mod_unit #(
  parameter int CAPACITY = dhks_pkg::CAPACITY_DEF,
  parameter int KW       = dhks_pkg::KEY_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [KW-1:0]               key_i,
  output logic                             done_o,
  output logic [$clog2(CAPACITY)-1:0]      rem_o,
  output logic [dhks_pkg::REM7_W-1:0]      rem7_o
);
  import dhks_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int RW    = IDX_W + 1;
  localparam int R7W   = REM7_W + 1;
  localparam longint unsigned KEY_SPAN = 64'd1 << KW;
  // Reciprocals rounded down: the estimated quotient is low by at most one.
  localparam logic [KW-1:0]  RECIP   = KW'(KEY_SPAN / 64'(CAPACITY));
  localparam logic [KW-1:0]  RECIP7  = KW'(KEY_SPAN / 64'(STEP_PRIME));
  localparam logic [RW-1:0]  CAP_R   = RW'(CAPACITY);
  localparam logic [R7W-1:0] SEVEN_R = R7W'(STEP_PRIME);

  logic              stg1_q;
  logic              stg2_q;
  logic              done_q;
  logic [KW-1:0]     key_q;
  logic [2*KW-1:0]   prod_q;
  logic [2*KW-1:0]   prod7_q;
  logic [IDX_W-1:0]  rem_q;
  logic [REM7_W-1:0] rem7_q;
  logic [KW-1:0]     quo;
  logic [KW-1:0]     quo7;
  logic [RW-1:0]     est;
  logic [R7W-1:0]    est7;
  logic [RW-1:0]     r;
  logic [R7W-1:0]    r7;

  assign quo  = prod_q[2*KW-1:KW];
  assign quo7 = prod7_q[2*KW-1:KW];
  // The true difference lies below twice the modulus, so the low bits carry it.
  assign est  = RW'(key_q) - RW'(quo) * CAP_R;
  assign est7 = R7W'(key_q) - R7W'(quo7) * SEVEN_R;
  assign r    = (est >= CAP_R) ? (est - CAP_R) : est;
  assign r7   = (est7 >= SEVEN_R) ? (est7 - SEVEN_R) : est7;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg1_q <= 1'b0;
      stg2_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      stg1_q <= start_i;
      stg2_q <= stg1_q;
      done_q <= stg2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      key_q <= key_i;
    end
    if (stg1_q) begin
      prod_q  <= (2*KW)'(key_q) * (2*KW)'(RECIP);
      prod7_q <= (2*KW)'(key_q) * (2*KW)'(RECIP7);
    end
    if (stg2_q) begin
      rem_q  <= r[IDX_W-1:0];
      rem7_q <= r7[REM7_W-1:0];
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;
  assign rem7_o = rem7_q;

endmodule

`default_nettype wire

// ===== sv/dhks_slot_ram.sv =====
// Slot table: one write port and one read port with registered read data.
// Each word holds a slot tag above the stored key. No dependencies.
`default_nettype none

module dhks_slot_ram #(
  parameter int DEPTH = 1021,
  parameter int WIDTH = 34
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]              rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sv/double_hash_key_set.sv =====
// Double-hash key set: open-addressed table of nonzero keys, one slot memory.
// A transaction is accepted, its key reduced modulo the table size and modulo seven,
// its home slot read, then slots probed one a cycle, and its result registered to the output.
// One transaction in flight: the next is taken only once the last has left for the output;
// a zero key skips the reduction and the probes. A stalled result holds the input.
// After reset a clearing pass empties the table, input stalled.
`default_nettype none

module double_hash_key_set #(
  parameter int CAPACITY = dhks_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = dhks_pkg::KEY_BITS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire dhks_pkg::in_item_t  in_item_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output dhks_pkg::out_item_t      out_item_o
);
  import dhks_pkg::*;

  localparam int KW     = (KEY_BITS < KEY_FIELD_W) ? KEY_BITS : KEY_FIELD_W;
  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int WORD_W = KW + 2;
  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(CAPACITY - 1);
  localparam logic [IDX_W:0]    CAP_EXT  = (IDX_W + 1)'(CAPACITY);
  localparam logic [REM7_W-1:0] STEP_C   = REM7_W'(STEP_PRIME);

  state_e            state_q, state_d;
  logic [IDX_W-1:0]  clr_q, clr_d;
  logic [FUNC_W-1:0] func_q, func_d;
  logic [KW-1:0]     key_q, key_d;
  logic [IDX_W-1:0]  pos_q, pos_d;
  logic [IDX_W-1:0]  att_q, att_d;
  logic [REM7_W-1:0] step_q, step_d;
  logic              tomb_vld_q, tomb_vld_d;
  logic [IDX_W-1:0]  tomb_pos_q, tomb_pos_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  out_item_t         res_q, res_d;
  out_item_t         out_q, out_d;
  logic              out_vld_q, out_vld_d;

  logic              mod_start;
  logic              mod_done;
  logic [IDX_W-1:0]  mod_rem;
  logic [REM7_W-1:0] mod_rem7;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  logic [KW-1:0]     in_key;
  tag_e              rd_tag;
  logic [KW-1:0]     rd_key;
  logic [IDX_W:0]    nxt_sum;
  logic [IDX_W-1:0]  nxt_pos;
  logic              hit;
  logic              empty;
  logic              new_tomb;
  logic              spot_vld;
  logic [IDX_W-1:0]  spot;

  dhks_mod_unit #(
    .CAPACITY (CAPACITY),
    .KW       (KW)
  ) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mod_start),
    .key_i   (in_key),
    .done_o  (mod_done),
    .rem_o   (mod_rem),
    .rem7_o  (mod_rem7)
  );

  dhks_slot_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (WORD_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_key   = in_item_i.key[KW-1:0];
  assign rd_tag   = tag_e'(ram_rdata[WORD_W-1:KW]);
  assign rd_key   = ram_rdata[KW-1:0];
  assign nxt_sum  = {1'b0, pos_q} + (IDX_W + 1)'(step_q);
  assign nxt_pos  = (nxt_sum >= CAP_EXT) ? IDX_W'(nxt_sum - CAP_EXT) : nxt_sum[IDX_W-1:0];
  assign hit      = (rd_tag == TAG_USED) && (rd_key == key_q);
  assign empty    = (rd_tag == TAG_EMPTY);
  assign new_tomb = (rd_tag == TAG_TOMB) && !tomb_vld_q;
  // First tombstone on the chain wins; otherwise the slot that ends it.
  assign spot_vld = tomb_vld_q || new_tomb || empty;
  assign spot     = tomb_vld_q ? tomb_pos_q : pos_q;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

  always_comb begin
    logic [CNT_W-1:0]    cnt_nxt;
    logic [STATUS_W-1:0] stat;

    state_d    = state_q;
    clr_d      = clr_q;
    func_d     = func_q;
    key_d      = key_q;
    pos_d      = pos_q;
    att_d      = att_q;
    step_d     = step_q;
    tomb_vld_d = tomb_vld_q;
    tomb_pos_d = tomb_pos_q;
    cnt_d      = cnt_q;
    res_d      = res_q;
    out_d      = out_q;
    out_vld_d  = out_vld_q && out_stall_i;
    mod_start  = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = pos_q;
    ram_wdata  = {TAG_USED, key_q};
    ram_raddr  = nxt_pos;
    cnt_nxt    = cnt_q;
    stat       = STAT_OK;

    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = {TAG_EMPTY, KW'(0)};
        if (clr_q == LAST_IDX) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end

      ST_IDLE: begin
        if (in_valid_i) begin
          func_d = in_item_i.func;
          key_d  = in_key;
          if (in_key == '0) begin
            res_d.found  = 1'b0;
            res_d.status = STAT_ZERO_KEY;
            res_d.count  = COUNT_W'(cnt_q);
            state_d      = ST_DONE;
          end else begin
            mod_start = 1'b1;
            state_d   = ST_HASH;
          end
        end
      end

      ST_HASH: begin
        // Read the home slot as soon as the remainders settle.
        ram_raddr = mod_rem;
        if (mod_done) begin
          pos_d      = mod_rem;
          att_d      = '0;
          step_d     = STEP_C - mod_rem7;
          tomb_vld_d = 1'b0;
          state_d    = ST_PROBE;
        end
      end

      ST_PROBE: begin
        // Next slot is read every cycle; data of pos_q is on the port now.
        pos_d = nxt_pos;
        att_d = att_q + 1'b1;
        if (new_tomb) begin
          tomb_vld_d = 1'b1;
          tomb_pos_d = pos_q;
        end
        if (hit || empty || (att_q == LAST_IDX)) begin
          case (func_q)
            FUNC_INSERT: begin
              if (!hit) begin
                if (spot_vld) begin
                  ram_we    = 1'b1;
                  ram_waddr = spot;
                  ram_wdata = {TAG_USED, key_q};
                  cnt_nxt   = cnt_q + 1'b1;
                end else begin
                  stat = STAT_FULL;
                end
              end
            end
            FUNC_DELETE: begin
              if (hit) begin
                ram_we    = 1'b1;
                ram_waddr = pos_q;
                ram_wdata = {TAG_TOMB, key_q};
                if (cnt_q != '0) begin
                  cnt_nxt = cnt_q - 1'b1;
                end
              end
            end
            default: ;
          endcase
          cnt_d        = cnt_nxt;
          res_d.found  = hit;
          res_d.status = stat;
          res_d.count  = COUNT_W'(cnt_nxt);
          state_d      = ST_DONE;
        end
      end

      ST_DONE: begin
        // Hold the result until the output register is free.
        if (!out_vld_q || !out_stall_i) begin
          out_d     = res_q;
          out_vld_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_q      <= '0;
      tomb_vld_q <= 1'b0;
      cnt_q      <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      tomb_vld_q <= tomb_vld_d;
      cnt_q      <= cnt_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q     <= func_d;
    key_q      <= key_d;
    pos_q      <= pos_d;
    att_q      <= att_d;
    step_q     <= step_d;
    tomb_pos_q <= tomb_pos_d;
    res_q      <= res_d;
    out_q      <= out_d;
  end

endmodule

`default_nettype wire
